// ===== sv/assert_macros.svh =====
// assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/lifeca_pkg.sv =====
// shared constants, codes and controller/datapath types of the life grid core
package lifeca_pkg;

    localparam int GRID_ROWS_DEF = 64;
    localparam int GRID_COLS_DEF = 256;

    localparam int OP_W        = 2;
    localparam int ROW_W       = 6;
    localparam int COL_W       = 8;
    localparam int ROWS_CFG_W  = 7;
    localparam int COLS_CFG_W  = 9;
    localparam int COUNT_W     = 15;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;
    localparam int NBR_W       = 4;

    localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
    localparam logic [OP_W-1:0] OP_READ    = 2'd1;
    localparam logic [OP_W-1:0] OP_ADVANCE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

    localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = 7'd60;
    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 9'd200;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7FFF;

    // B3/S23 neighbour counts
    localparam logic [NBR_W-1:0] SURVIVE_LOW = 4'd2;
    localparam logic [NBR_W-1:0] BIRTH_COUNT = 4'd3;

    typedef enum logic [1:0] {
        RD_ACCESS,
        RD_ROW,
        RD_ROW1,
        RD_ROW2
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_CLEAR,
        WR_CELL,
        WR_ROW
    } wr_sel_t;

    typedef struct packed {
        logic    load_in;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        logic    row_inc;
        logic    load_here;
        logic    load_below;
        logic    shift_rows;
        logic    cell_step;
        logic    access_done;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic is_advance;
        logic area_empty;
        logic col_last;
        logic row_last;
        logic clear_last;
    } dp_status_t;

endpackage

// ===== sv/lifeca_ram.sv =====
// generic simple dual-port ram with registered read
module lifeca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/lifeca_ctrl.sv =====
// controller state machine of the life grid core
module lifeca_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    input  lifeca_pkg::dp_status_t status,
    output lifeca_pkg::dp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_ACC_DO,
        ST_ADV_HERE,
        ST_ADV_BELOW,
        ST_ADV_CELL,
        ST_ADV_WB,
        ST_FINISH
    } state_t;

    state_t state_reg;
    logic   m_valid_reg;

    always_comb
    begin
        cmd.load_in     = 1'b0;
        cmd.rd_sel      = lifeca_pkg::RD_ACCESS;
        cmd.wr_sel      = lifeca_pkg::WR_NONE;
        cmd.row_inc     = 1'b0;
        cmd.load_here   = 1'b0;
        cmd.load_below  = 1'b0;
        cmd.shift_rows  = 1'b0;
        cmd.cell_step   = 1'b0;
        cmd.access_done = 1'b0;
        cmd.load_out    = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.wr_sel  = lifeca_pkg::WR_CLEAR;
                cmd.row_inc = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.load_in = s_tvalid;
            end
            ST_DECODE:
            begin
                cmd.rd_sel = status.is_advance ? lifeca_pkg::RD_ROW : lifeca_pkg::RD_ACCESS;
            end
            ST_ACC_DO:
            begin
                cmd.wr_sel      = lifeca_pkg::WR_CELL;
                cmd.access_done = 1'b1;
            end
            ST_ADV_HERE:
            begin
                cmd.load_here = 1'b1;
                cmd.rd_sel    = lifeca_pkg::RD_ROW1;
            end
            ST_ADV_BELOW:
            begin
                cmd.load_below = 1'b1;
            end
            ST_ADV_CELL:
            begin
                cmd.cell_step = 1'b1;
            end
            ST_ADV_WB:
            begin
                cmd.wr_sel     = lifeca_pkg::WR_ROW;
                cmd.shift_rows = 1'b1;
                cmd.row_inc    = 1'b1;
                cmd.rd_sel     = lifeca_pkg::RD_ROW2;
            end
            ST_FINISH:
            begin
                cmd.load_out = !m_valid_reg || m_tready;
            end
            default:
            begin
                cmd.load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (status.clear_last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE:
                begin
                    if (!status.is_advance)
                    begin
                        state_reg <= ST_ACC_DO;
                    end
                    else if (status.area_empty)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        state_reg <= ST_ADV_HERE;
                    end
                end
                ST_ACC_DO:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_ADV_HERE:
                begin
                    state_reg <= ST_ADV_BELOW;
                end
                ST_ADV_BELOW:
                begin
                    state_reg <= ST_ADV_CELL;
                end
                ST_ADV_CELL:
                begin
                    if (status.col_last)
                    begin
                        state_reg <= ST_ADV_WB;
                    end
                end
                ST_ADV_WB:
                begin
                    state_reg <= status.row_last ? ST_FINISH : ST_ADV_BELOW;
                end
                ST_FINISH:
                begin
                    if (cmd.load_out)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

// ===== sv/lifeca_dp.sv =====
// datapath of the life grid core: grid ram, row copies, neighbour count, population
module lifeca_dp #(
    parameter int GRID_ROWS = lifeca_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = lifeca_pkg::GRID_COLS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic [lifeca_pkg::IN_TDATA_W-1:0]       s_tdata,
    output logic [lifeca_pkg::OUT_TDATA_W-1:0]      m_tdata,
    input  logic                                    cfg_write,
    input  logic [lifeca_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lifeca_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  lifeca_pkg::dp_cmd_t                     cmd,
    output lifeca_pkg::dp_status_t                  status
);

    localparam int RAW = $clog2(GRID_ROWS);
    localparam int CIW = $clog2(GRID_COLS);
    localparam int NRW = ($clog2(GRID_ROWS + 1) > lifeca_pkg::ROWS_CFG_W) ?
                         $clog2(GRID_ROWS + 1) : lifeca_pkg::ROWS_CFG_W;
    localparam int NCW = ($clog2(GRID_COLS + 1) > lifeca_pkg::COLS_CFG_W) ?
                         $clog2(GRID_COLS + 1) : lifeca_pkg::COLS_CFG_W;
    localparam int NBW = lifeca_pkg::NBR_W;

    // configuration and control counters
    logic [lifeca_pkg::ROWS_CFG_W-1:0] rows_cfg_reg;
    logic [lifeca_pkg::COLS_CFG_W-1:0] cols_cfg_reg;
    logic [RAW-1:0]                    r_cnt_reg, r_cnt_next;
    logic [CIW-1:0]                    c_cnt_reg, c_cnt_next;

    // latched word and row copies
    logic [lifeca_pkg::OP_W-1:0]       op_reg;
    logic [lifeca_pkg::ROW_W-1:0]      row_reg;
    logic [lifeca_pkg::COL_W-1:0]      col_reg;
    logic                              alive_reg;
    logic [GRID_COLS-1:0]              above_reg, above_next;
    logic [GRID_COLS-1:0]              here_reg, here_next;
    logic [GRID_COLS-1:0]              below_reg, below_next;
    logic [GRID_COLS-1:0]              new_row_reg, new_row_next;
    logic [lifeca_pkg::COUNT_W-1:0]    pop_reg, pop_next;
    logic                              res_alive_reg, res_alive_next;
    logic                              out_alive_reg;
    logic [lifeca_pkg::COUNT_W-1:0]    out_count_reg;

    // ram port
    logic                              ram_we;
    logic [RAW-1:0]                    ram_waddr;
    logic [RAW-1:0]                    ram_raddr;
    logic [GRID_COLS-1:0]              ram_wdata;
    logic [GRID_COLS-1:0]              ram_rdata;
    logic [GRID_COLS-1:0]              cell_wdata;

    logic [NRW-1:0]                    nr;
    logic [NCW-1:0]                    nc;
    logic                              in_area;
    logic                              has_below;
    logic                              has_left, has_right;
    logic [RAW-1:0]                    row_idx;
    logic [CIW-1:0]                    col_idx;
    logic [CIW-1:0]                    c_left, c_right;
    logic [NBW-1:0]                    nbr;
    logic                              new_bit;

    lifeca_ram #(
        .WIDTH (GRID_COLS),
        .DEPTH (GRID_ROWS)
    ) u_grid_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // active area, clamped to the grid size
    assign nr = (NRW'(rows_cfg_reg) > NRW'(GRID_ROWS)) ? NRW'(GRID_ROWS) : NRW'(rows_cfg_reg);
    assign nc = (NCW'(cols_cfg_reg) > NCW'(GRID_COLS)) ? NCW'(GRID_COLS) : NCW'(cols_cfg_reg);

    assign row_idx   = RAW'(row_reg);
    assign col_idx   = CIW'(col_reg);
    assign in_area   = (NRW'(row_reg) < nr) && (NCW'(col_reg) < nc);
    assign has_below = (NRW'(r_cnt_reg) + NRW'(1)) < nr;

    // neighbour count of the current cell from the three saved rows
    assign has_left  = (c_cnt_reg != '0);
    assign has_right = (NCW'(c_cnt_reg) + NCW'(1)) < nc;
    assign c_left    = c_cnt_reg - CIW'(1);
    assign c_right   = c_cnt_reg + CIW'(1);

    always_comb
    begin
        nbr = NBW'(above_reg[c_cnt_reg]) + NBW'(below_reg[c_cnt_reg])
            + NBW'(has_left ? above_reg[c_left] : 1'b0)
            + NBW'(has_left ? here_reg[c_left] : 1'b0)
            + NBW'(has_left ? below_reg[c_left] : 1'b0)
            + NBW'(has_right ? above_reg[c_right] : 1'b0)
            + NBW'(has_right ? here_reg[c_right] : 1'b0)
            + NBW'(has_right ? below_reg[c_right] : 1'b0);
        if (here_reg[c_cnt_reg])
        begin
            new_bit = (nbr == lifeca_pkg::SURVIVE_LOW) || (nbr == lifeca_pkg::BIRTH_COUNT);
        end
        else
        begin
            new_bit = (nbr == lifeca_pkg::BIRTH_COUNT);
        end
    end

    // single-cell read-modify-write data
    always_comb
    begin
        cell_wdata          = ram_rdata;
        cell_wdata[col_idx] = alive_reg;
    end

    always_comb
    begin
        unique case (cmd.rd_sel)
            lifeca_pkg::RD_ACCESS: ram_raddr = row_idx;
            lifeca_pkg::RD_ROW:    ram_raddr = r_cnt_reg;
            lifeca_pkg::RD_ROW1:   ram_raddr = r_cnt_reg + RAW'(1);
            lifeca_pkg::RD_ROW2:   ram_raddr = r_cnt_reg + RAW'(2);
            default:               ram_raddr = row_idx;
        endcase
    end

    always_comb
    begin
        unique case (cmd.wr_sel)
            lifeca_pkg::WR_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt_reg;
                ram_wdata = '0;
            end
            lifeca_pkg::WR_CELL:
            begin
                ram_we    = (op_reg == lifeca_pkg::OP_WRITE) && in_area;
                ram_waddr = row_idx;
                ram_wdata = cell_wdata;
            end
            lifeca_pkg::WR_ROW:
            begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt_reg;
                ram_wdata = new_row_reg;
            end
            default:
            begin
                ram_we    = 1'b0;
                ram_waddr = r_cnt_reg;
                ram_wdata = new_row_reg;
            end
        endcase
    end

    always_comb
    begin
        r_cnt_next     = r_cnt_reg;
        c_cnt_next     = c_cnt_reg;
        above_next     = above_reg;
        here_next      = here_reg;
        below_next     = below_reg;
        new_row_next   = new_row_reg;
        pop_next       = pop_reg;
        res_alive_next = res_alive_reg;

        if (cmd.load_in)
        begin
            r_cnt_next     = '0;
            pop_next       = '0;
            res_alive_next = 1'b0;
        end
        if (cmd.row_inc)
        begin
            r_cnt_next = r_cnt_reg + RAW'(1);
        end
        if (cmd.access_done)
        begin
            res_alive_next = (op_reg == lifeca_pkg::OP_READ) && in_area && ram_rdata[col_idx];
        end
        if (cmd.load_here)
        begin
            above_next   = '0;
            here_next    = ram_rdata;
            new_row_next = ram_rdata;
        end
        if (cmd.load_below)
        begin
            below_next = has_below ? ram_rdata : '0;
            c_cnt_next = '0;
        end
        if (cmd.cell_step)
        begin
            new_row_next[c_cnt_reg] = new_bit;
            c_cnt_next              = c_cnt_reg + CIW'(1);
            if (new_bit && (pop_reg != lifeca_pkg::COUNT_MAX))
            begin
                pop_next = pop_reg + lifeca_pkg::COUNT_W'(1);
            end
        end
        // old row r becomes the row above; the row below keeps its old bits
        if (cmd.shift_rows)
        begin
            above_next   = here_reg;
            here_next    = below_reg;
            new_row_next = below_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= lifeca_pkg::ROWS_RESET;
            cols_cfg_reg <= lifeca_pkg::COLS_RESET;
            r_cnt_reg    <= '0;
            c_cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == lifeca_pkg::CFG_ROWS)
                begin
                    rows_cfg_reg <= cfg_data[lifeca_pkg::ROWS_CFG_W-1:0];
                end
                else
                begin
                    cols_cfg_reg <= cfg_data[lifeca_pkg::COLS_CFG_W-1:0];
                end
            end
            r_cnt_reg <= r_cnt_next;
            c_cnt_reg <= c_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg    <= s_tdata[1:0];
            row_reg   <= s_tdata[7:2];
            col_reg   <= s_tdata[15:8];
            alive_reg <= s_tdata[16];
        end
        if (cmd.load_out)
        begin
            out_alive_reg <= res_alive_reg;
            out_count_reg <= pop_reg;
        end
        above_reg     <= above_next;
        here_reg      <= here_next;
        below_reg     <= below_next;
        new_row_reg   <= new_row_next;
        pop_reg       <= pop_next;
        res_alive_reg <= res_alive_next;
    end

    assign status.is_advance = (op_reg == lifeca_pkg::OP_ADVANCE);
    assign status.area_empty = (nr == '0) || (nc == '0);
    assign status.col_last   = !has_right;
    assign status.row_last   = !has_below;
    assign status.clear_last = (r_cnt_reg == RAW'(GRID_ROWS - 1));

    assign m_tdata = {out_count_reg, out_alive_reg};

endmodule

// ===== sv/life_cellular_automaton_grid_core.sv =====
// top level of the B3/S23 life grid core
// Usage:
//   s_tdata word (accepted on s_tvalid & s_tready): operation, row, col, alive_in.
//   operation write stores alive_in at (row, col), read returns that cell,
//   advance computes one synchronous generation over the active area.
//   m_tdata word carries cell_alive and live_count, one word per accepted word.
//   cfg channel writes rows_in_use (index 0) or cols_in_use (index 1); it is
//   always ready and is meant to be written while the core is idle.
// Timing:
//   after reset the grid ram is cleared one row per cycle, all GRID_ROWS rows,
//   and s_tready stays low until that pass is done.
//   read and write: decode and access states, then the finish state loads m_tvalid.
//   advance: walks the active rows and columns one cell per cycle through the
//   single neighbour-count unit, plus a row write-back and row fetch per row.
//   One word is processed at a time; a new word is accepted as soon as the
//   previous one is finished, even while its result still waits in the
//   output register. If m_tready is held low, a finished result waits in
//   the controller until the output register frees up.
module life_cellular_automaton_grid_core #(
    parameter int GRID_ROWS = lifeca_pkg::GRID_ROWS_DEF,
    parameter int GRID_COLS = lifeca_pkg::GRID_COLS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // s_tdata: operation[1:0], row[7:2], col[15:8], alive_in[16], zero pad [23:17]
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [lifeca_pkg::IN_TDATA_W-1:0]     s_tdata,
    // m_tdata: cell_alive[0], live_count[15:1]
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [lifeca_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lifeca_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lifeca_pkg::CFG_DATA_W-1:0]     cfg_data
);

    lifeca_pkg::dp_cmd_t    cmd;
    lifeca_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    lifeca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lifeca_dp #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== sv/lifeca_checker.sv =====
// port-level checker of the life grid core, bound to the top level
`include "assert_macros.svh"

module lifeca_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [lifeca_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // stalled result stays put
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // one word at a time: no acceptance right after an acceptance
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, s_tvalid && s_tready, !s_tready, "input accepted while busy")

    // a result carries a cell value or a population, never both
    `ASSERT_IMPLY(a_one_field, clk, rst_n, m_tvalid, !(m_tdata[0] && (m_tdata[15:1] != 15'd0)), "both result fields set")

endmodule

bind life_cellular_automaton_grid_core lifeca_checker u_lifeca_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
